[rtl/crc8_stuffing_frame_builder_macros.svh]
// Assertion macros used by the frame builder checker.
`ifndef CRC8_STUFFING_FRAME_BUILDER_MACROS_SVH
`define CRC8_STUFFING_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CSFB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csfb check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CSFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csfb check failed");

`endif

[rtl/csfb_pkg.sv]
// Shared types, constants and helpers of the CRC-8 byte-stuffing frame builder.
package csfb_pkg;

  localparam int unsigned FRAME_LIMIT_MAX = 4096;
  localparam int unsigned FRAME_LIMIT_MIN = 8;

  // Frame byte counter and the width used for limit compares.
  localparam int unsigned CNT_W = $clog2(FRAME_LIMIT_MAX + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // Configuration port.
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LIM_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRC_INIT     = 3'd0,
    REG_CRC_POLY     = 3'd1,
    REG_START_FIRST  = 3'd2,
    REG_START_SECOND = 3'd3,
    REG_STOP_VALUE   = 3'd4,
    REG_MAX_LEN      = 3'd5
  } csfb_reg_e;

  localparam logic [7:0]       RST_CRC_INIT     = 8'h00;
  localparam logic [7:0]       RST_CRC_POLY     = 8'h07;
  localparam logic [7:0]       RST_START_FIRST  = 8'h73;
  localparam logic [7:0]       RST_START_SECOND = 8'h55;
  localparam logic [7:0]       RST_STOP_VALUE   = 8'h55;
  localparam logic [LEN_W-1:0] RST_MAX_LEN      = 13'd256;

  // Escaping.
  localparam logic [7:0] ESC_FLAG     = 8'h55;
  localparam logic [7:0] ESC_CHAR     = 8'h73;
  localparam logic [7:0] ESC_FLAG_SUB = 8'h11;
  localparam logic [7:0] ESC_CHAR_SUB = 8'h22;
  localparam logic [7:0] CRC_MSB      = 8'h80;

  // Output slots of one item, in send order.
  localparam int unsigned NSLOT        = 7;
  localparam int unsigned SLOT_START0  = 0;
  localparam int unsigned SLOT_START1  = 1;
  localparam int unsigned SLOT_DATA0   = 2;
  localparam int unsigned SLOT_DATA1   = 3;
  localparam int unsigned SLOT_CRC0    = 4;
  localparam int unsigned SLOT_CRC1    = 5;
  localparam int unsigned SLOT_STOP    = 6;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]       crc_init;
    logic [7:0]       crc_poly;
    logic [7:0]       start_first;
    logic [7:0]       start_second;
    logic [7:0]       stop_value;
    logic [LEN_W-1:0] max_frame_len;
  } csfb_cfg_t;

  // One classified item: what the back end has to send for it.
  typedef struct packed {
    logic       start;
    logic [1:0] data_n;
    logic [7:0] data;
    logic [1:0] crc_n;
    logic [7:0] crc;
    logic       stop;
    logic       ovf;
  } csfb_rec_t;

  function automatic logic is_esc(input logic [7:0] b);
    return (b == ESC_FLAG) || (b == ESC_CHAR);
  endfunction

endpackage

[rtl/csfb_if.sv]
// Valid/ready channel interfaces for body bytes in and framed bytes out.
interface csfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface csfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       overflow;

  modport source (output valid, out_byte, run_last, frame_end, overflow, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, overflow, output ready);
endinterface

[rtl/csfb_front.sv]
// Front end: accepts body bytes, runs CRC and frame-limit accounting, classifies.
module csfb_front import csfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  csfb_cfg_t  cfg_i,
  csfb_in_if.sink    in_i,
  input  logic       q_ready_i,
  output logic       push_o,
  output csfb_rec_t  rec_o
);

  logic             in_frame_q, in_frame_d;
  logic [7:0]       crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovl_q, ovl_d;

  logic             accept;
  logic             start;
  logic [CNT_W-1:0] base, cnt1;
  logic             ovl0, ovl1, ovl2;
  logic [7:0]       crc0, crc1;
  logic [1:0]       dlen, clen;
  logic             d_fit, c_fit;
  logic [LIM_W-1:0] len_ext, lim_w;
  logic [SUM_W-1:0] lim;

  function automatic logic [7:0] crc_step(input logic [7:0] crc_in,
                                          input logic [7:0] d_in,
                                          input logic [7:0] poly);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = d_in;
    for (int i = 0; i < 8; i++) begin
      if (((d ^ c) & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid & q_ready_i;

  always_comb begin
    len_ext = LIM_W'(cfg_i.max_frame_len);
    if (len_ext < LIM_W'(FRAME_LIMIT_MIN)) begin
      lim_w = LIM_W'(FRAME_LIMIT_MIN);
    end else if (len_ext > LIM_W'(FRAME_LIMIT_MAX)) begin
      lim_w = LIM_W'(FRAME_LIMIT_MAX);
    end else begin
      lim_w = len_ext;
    end
    lim = SUM_W'(lim_w);

    start = ~in_frame_q;
    base  = start ? CNT_W'(2) : cnt_q;
    ovl0  = start ? 1'b0 : ovl_q;
    crc0  = start ? cfg_i.crc_init : crc_q;
    crc1  = crc_step(crc0, in_i.data_byte, cfg_i.crc_poly);

    // body byte, escape pair kept whole; one slot stays free for the stop byte
    dlen  = is_esc(in_i.data_byte) ? 2'd2 : 2'd1;
    d_fit = ~ovl0 & ((SUM_W'(base) + SUM_W'(dlen) + SUM_W'(1)) <= lim);
    cnt1  = d_fit ? (base + CNT_W'(dlen)) : base;
    ovl1  = ovl0 | ~d_fit;

    clen  = is_esc(crc1) ? 2'd2 : 2'd1;
    c_fit = in_i.last_byte & ~ovl1 & ((SUM_W'(cnt1) + SUM_W'(clen) + SUM_W'(1)) <= lim);
    ovl2  = ovl1 | (in_i.last_byte & ~c_fit);

    rec_o.start  = start;
    rec_o.data_n = d_fit ? dlen : 2'd0;
    rec_o.data   = in_i.data_byte;
    rec_o.crc_n  = c_fit ? clen : 2'd0;
    rec_o.crc    = crc1;
    rec_o.stop   = in_i.last_byte;
    rec_o.ovf    = ovl2;

    // an item whose bytes are all dropped sends nothing
    push_o = accept & (start | d_fit | in_i.last_byte);

    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    ovl_d      = ovl_q;
    if (accept) begin
      in_frame_d = ~in_i.last_byte;
      crc_d      = crc1;
      cnt_d      = c_fit ? (cnt1 + CNT_W'(clen)) : cnt1;
      ovl_d      = ovl2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= 8'h00;
      cnt_q      <= '0;
      ovl_q      <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
      cnt_q      <= cnt_d;
      ovl_q      <= ovl_d;
    end
  end

endmodule

[rtl/csfb_queue.sv]
// Short queue of classified items between the front and back ends.
module csfb_queue import csfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  csfb_rec_t rec_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output csfb_rec_t rec_o
);

  csfb_rec_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

endmodule

[rtl/csfb_back.sv]
// Back end: expands one classified item into framed bytes, one per cycle while the receiver takes them.
module csfb_back import csfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  csfb_cfg_t  cfg_i,
  input  logic       head_valid_i,
  input  csfb_rec_t  head_i,
  output logic       pop_o,
  csfb_out_if.source out_o
);

  logic             loaded_q, loaded_d;
  logic [NSLOT-1:0] mask_q, mask_d;
  logic             ov_q, ov_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             fend_q, fend_d;
  logic             ovf_q, ovf_d;

  logic [NSLOT-1:0] head_mask, cur, low, rest;
  logic [7:0]       sb [NSLOT];
  logic [7:0]       sel;
  logic             fire;

  always_comb begin
    head_mask[SLOT_START0] = head_i.start;
    head_mask[SLOT_START1] = head_i.start;
    head_mask[SLOT_DATA0]  = (head_i.data_n != 2'd0);
    head_mask[SLOT_DATA1]  = (head_i.data_n == 2'd2);
    head_mask[SLOT_CRC0]   = (head_i.crc_n != 2'd0);
    head_mask[SLOT_CRC1]   = (head_i.crc_n == 2'd2);
    head_mask[SLOT_STOP]   = head_i.stop;

    sb[SLOT_START0] = cfg_i.start_first;
    sb[SLOT_START1] = cfg_i.start_second;
    sb[SLOT_DATA0]  = (head_i.data_n == 2'd2) ? ESC_CHAR : head_i.data;
    sb[SLOT_DATA1]  = (head_i.data == ESC_FLAG) ? ESC_FLAG_SUB : ESC_CHAR_SUB;
    sb[SLOT_CRC0]   = (head_i.crc_n == 2'd2) ? ESC_CHAR : head_i.crc;
    sb[SLOT_CRC1]   = (head_i.crc == ESC_FLAG) ? ESC_FLAG_SUB : ESC_CHAR_SUB;
    sb[SLOT_STOP]   = cfg_i.stop_value;

    // next slot to send is the lowest one still pending
    cur  = loaded_q ? mask_q : head_mask;
    low  = cur & (~cur + NSLOT'(1));
    rest = cur & ~low;

    sel = 8'h00;
    for (int i = 0; i < NSLOT; i++) begin
      if (low[i]) begin
        sel = sel | sb[i];
      end
    end

    fire  = head_valid_i & (~ov_q | out_o.ready);
    pop_o = fire & (rest == '0);

    loaded_d = loaded_q;
    mask_d   = mask_q;
    ov_d     = ov_q & ~out_o.ready;
    byte_d   = byte_q;
    last_d   = last_q;
    fend_d   = fend_q;
    ovf_d    = ovf_q;
    if (fire) begin
      loaded_d = (rest != '0);
      mask_d   = rest;
      ov_d     = 1'b1;
      byte_d   = sel;
      last_d   = (rest == '0);
      fend_d   = low[SLOT_STOP];
      ovf_d    = low[SLOT_STOP] & head_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      mask_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      mask_q   <= mask_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    fend_q <= fend_d;
    ovf_q  <= ovf_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.run_last  = last_q;
  assign out_o.frame_end = fend_q;
  assign out_o.overflow  = ovf_q;

endmodule

[rtl/crc8_stuffing_frame_builder.sv]
// CRC-8 byte-stuffing frame builder: top level with configuration registers.
//
// in_i takes unframed body bytes (data_byte, last_byte on the final one) by
// valid/ready; out_o gives the framed stream: two start bytes before the first
// body byte, each body byte escaped (0x55 -> 0x73 0x11, 0x73 -> 0x73 0x22),
// then the escaped CRC-8 and the stop byte after the last one. run_last marks
// the final byte of an input transfer, frame_end the stop byte, overflow a
// stop byte whose frame lost bytes to the max_frame_len limit.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// do so only while idle, which the block itself leaves unenforced. The first
// byte of an item passes through the queue and the output register before it
// shows on out_o. Throughput: one output byte per cycle while the receiver is
// ready, set by the back-end byte serialiser; an item produces 1 to 7 bytes,
// and plain body bytes flow at one per cycle while the receiver is ready. A
// two-entry queue decouples the CRC/limit front end from the serialiser. When
// the receiver stalls, the output register holds, the queue fills and
// in_i.ready drops. Reset clears the frame state, empties the queue and the
// output, and loads the register defaults.
module crc8_stuffing_frame_builder import csfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  csfb_in_if.sink              in_i,
  csfb_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  csfb_cfg_t cfg_q, cfg_d;
  csfb_rec_t front_rec, head_rec;
  logic      push, q_ready, head_valid, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CRC_INIT:     cfg_d.crc_init      = cfg_data_i[7:0];
        REG_CRC_POLY:     cfg_d.crc_poly      = cfg_data_i[7:0];
        REG_START_FIRST:  cfg_d.start_first   = cfg_data_i[7:0];
        REG_START_SECOND: cfg_d.start_second  = cfg_data_i[7:0];
        REG_STOP_VALUE:   cfg_d.stop_value    = cfg_data_i[7:0];
        REG_MAX_LEN:      cfg_d.max_frame_len = cfg_data_i[LEN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_init      <= RST_CRC_INIT;
      cfg_q.crc_poly      <= RST_CRC_POLY;
      cfg_q.start_first   <= RST_START_FIRST;
      cfg_q.start_second  <= RST_START_SECOND;
      cfg_q.stop_value    <= RST_STOP_VALUE;
      cfg_q.max_frame_len <= RST_MAX_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  csfb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .rec_o     (front_rec)
  );

  csfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rec_o   (head_rec)
  );

  csfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_rec),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[rtl/csfb_checker.sv]
// Port-level checks on the framed output stream, bound to the top level.
`include "crc8_stuffing_frame_builder_macros.svh"

module csfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_last_i,
  input logic       frame_end_i,
  input logic       overflow_i
);

  // a stop byte always closes the bytes of its input transfer
  `CSFB_ASSERT_SAME(a_stop_is_run_last, out_valid_i && frame_end_i, run_last_i)

  // overflow is only ever flagged on the stop byte
  `CSFB_ASSERT_SAME(a_ovf_on_stop, out_valid_i && overflow_i, frame_end_i)

  `CSFB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  `CSFB_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
    $stable(out_byte_i) && $stable(run_last_i) && $stable(frame_end_i) && $stable(overflow_i))

endmodule

bind crc8_stuffing_frame_builder csfb_checker u_csfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .run_last_i  (out_o.run_last),
  .frame_end_i (out_o.frame_end),
  .overflow_i  (out_o.overflow)
);
